>>> hdl/glmi_pkg.sv
// package for the galvo linear move interpolator
// beat types, codes and constants shared by the core, the step unit and the checker
package glmi_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_FEED  = 2'd0;
    localparam logic [1:0] CFG_STOP  = 2'd1;
    localparam logic [1:0] CFG_GUIDE = 2'd2;

    // input beat function codes
    localparam logic FUNC_MOVE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_JUMP  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;
    localparam logic [1:0] KIND_POINT = 2'd3;

    localparam int          UNITS_PER_MM_DEF = 200;
    localparam logic [19:0] DWELL_MAX        = 20'hFFFFF;
    localparam logic [25:0] US_PER_MIN       = 26'd60000000;

    // shared step unit widths
    localparam int UREM_W = 58;
    localparam int USRC_W = 50;
    localparam int UDIV_W = 57;
    localparam int UACC_W = 25;

    typedef struct packed {
        logic        func;
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [15:0] target_x;
        logic [15:0] target_y;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [19:0] step_dwell;
        logic        laser_enable;
        logic        last;
    } t_out_item;

    typedef enum logic {
        UM_SQRT = 1'b0,
        UM_DIV  = 1'b1
    } t_unit_mode;

    typedef struct packed {
        logic              start;
        t_unit_mode        mode;
        logic [UREM_W-1:0] rem;
        logic [USRC_W-1:0] src;
        logic [UDIV_W-1:0] div;
        logic [4:0]        steps;
    } t_unit_cmd;

    typedef struct packed {
        logic              done;
        logic [UACC_W-1:0] acc;
    } t_unit_stat;

endpackage

>>> hdl/glmi_shsub.sv
// shared shift and subtract unit: restoring square root or restoring division
// one result bit per cycle; depends on glmi_pkg
module glmi_shsub import glmi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_unit_cmd  i_cmd,
    output t_unit_stat o_stat
);

    logic              r_busy;
    logic              r_done;
    logic [4:0]        r_cnt;
    t_unit_mode        r_mode;
    logic [UREM_W-1:0] r_rem;
    logic [USRC_W-1:0] r_src;
    logic [UDIV_W-1:0] r_div;
    logic [UACC_W-1:0] r_acc;

    logic [UREM_W-1:0] cand;
    logic [UREM_W-1:0] trial;
    logic              ge;

    // one compare and subtract step
    always_comb begin
        unique case (r_mode)
            UM_SQRT: begin
                cand  = {r_rem[UREM_W-3:0], r_src[USRC_W-1 -: 2]};
                trial = {{(UREM_W-UACC_W-2){1'b0}}, r_acc, 2'b01};
            end
            UM_DIV: begin
                cand  = {r_rem[UREM_W-2:0], r_src[USRC_W-1]};
                trial = {{(UREM_W-UDIV_W){1'b0}}, r_div};
            end
            default: begin
                cand  = '0;
                trial = '0;
            end
        endcase
        ge = (cand >= trial);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode <= i_cmd.mode;
            r_rem  <= i_cmd.rem;
            r_src  <= i_cmd.src;
            r_div  <= i_cmd.div;
            r_acc  <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? (cand - trial) : cand;
            r_acc <= {r_acc[UACC_W-2:0], ge};
            if (r_mode == UM_SQRT) begin
                r_src <= {r_src[USRC_W-3:0], 2'b00};
            end else begin
                r_src <= {r_src[USRC_W-2:0], 1'b0};
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.acc  = r_acc;

endmodule

>>> hdl/galvo_linear_move_interpolator.sv
// galvo linear move interpolator top level: sequencer, move state and beat registers
// depends on glmi_pkg and glmi_shsub
//
// usage
//   input channel: i_in_valid / o_in_stall / i_in_data. a move beat (func 0) carries
//   start and target; a tick beat (func 1) asks for the next path point.
//   output channel: o_out_valid / i_out_stall / o_out_data, at most one beat per input.
//   config: i_cfg_we / i_cfg_idx / i_cfg_data, written while the block is idle.
//   a timed move runs the multiplies, the square root, the setup and multiply steps,
//   the division and the output load; a saturated dwell skips the division; no motion
//   or a jump goes from the square root to the output load. a path point takes two
//   rounds of multiply and division, then the output load; the final point goes
//   straight to the output load. an idle tick gives no beat and the block stays ready.
//   the next input beat can be taken in the cycle after the result is loaded.
//   the shared shift and subtract unit makes one result bit a cycle.
//   one beat is worked on at a time: o_in_stall is high until its result is loaded
//   into the output register. a waiting output beat does not block the next input
//   beat; a new result waits until the output register is free.
//   reset clears the config registers, the move state and the output valid.
//   while the receiver stalls, the output beat holds.
module galvo_linear_move_interpolator import glmi_pkg::*; #(
    parameter int UNITS_PER_MM = UNITS_PER_MM_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam logic [15:0] UPM = UNITS_PER_MM[15:0];

    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_SQX  = 16'h0002,
        S_SQY  = 16'h0004,
        S_SQS  = 16'h0008,
        S_ROOT = 16'h0010,
        S_CLS  = 16'h0020,
        S_M2   = 16'h0040,
        S_M3   = 16'h0080,
        S_M4   = 16'h0100,
        S_CHK  = 16'h0200,
        S_DIV  = 16'h0400,
        S_PX   = 16'h0800,
        S_PM   = 16'h1000,
        S_PSUM = 16'h2000,
        S_PDIV = 16'h4000,
        S_OUT  = 16'h8000
    } t_state;

    t_state r_state, n_state;

    logic [15:0] r_feed;
    logic        r_stop;
    logic        r_guide;
    logic [15:0] r_ox, r_oy;
    logic signed [16:0] r_dx, r_dy;
    logic [16:0] r_cnt, n_cnt;
    logic [16:0] r_idx, n_idx;
    logic        r_active, n_active;
    logic        r_laser;
    logic        r_axis, n_axis;
    logic [15:0] r_px, n_px;
    logic signed [59:0] r_p;
    logic [32:0] r_sq;
    logic [24:0] r_dist;
    logic [50:0] r_num;
    logic [56:0] r_den;
    logic signed [34:0] r_t;
    t_out_item   r_res, n_res;
    logic        r_ovalid;
    t_out_item   r_odata;

    logic signed [33:0] mul_a;
    logic [25:0]        mul_b;
    logic [16:0]        abs_dx, abs_dy;
    logic [16:0]        steps;
    logic [16:0]        idx_inc;
    logic [15:0]        end_x, end_y;
    logic signed [39:0] tnum;
    logic [39:0]        tnum_c;
    logic               out_free;
    t_unit_cmd          ucmd;
    t_unit_stat         ustat;

    glmi_shsub u_shsub (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (ucmd),
        .o_stat (ustat)
    );

    assign abs_dx  = r_dx[16] ? 17'(-r_dx) : 17'(r_dx);
    assign abs_dy  = r_dy[16] ? 17'(-r_dy) : 17'(r_dy);
    assign steps   = (r_dist[24:8] == 17'd0) ? 17'd1 : r_dist[24:8];
    assign idx_inc = r_idx + 17'd1;
    assign end_x   = r_ox + r_dx[15:0];
    assign end_y   = r_oy + r_dy[15:0];
    // delta times index is signed, so both terms are sign extended
    assign tnum    = 40'(({{5{r_t[34]}}, r_t} + {{5{r_p[34]}}, r_p[34:0]}) <<< 1)
                   + 40'(signed'({23'b0, r_cnt}));
    assign tnum_c  = tnum[39] ? 40'd0 : 40'(tnum);
    assign out_free = !r_ovalid || !i_out_stall;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQX:  begin mul_a = 34'(abs_dx); mul_b = 26'(abs_dx); end
            S_SQY:  begin mul_a = 34'(abs_dy); mul_b = 26'(abs_dy); end
            S_CLS:  begin mul_a = 34'(US_PER_MIN); mul_b = 26'(r_dist); end
            S_M2:   begin mul_a = 34'(UPM); mul_b = 26'(r_cnt); end
            S_M3:   begin mul_a = 34'(r_p[32:0]); mul_b = 26'(r_feed); end
            S_PX:   begin mul_a = 34'(r_axis ? r_oy : r_ox); mul_b = 26'(r_cnt); end
            S_PM:   begin
                mul_a = r_axis ? 34'(signed'(r_dy)) : 34'(signed'(r_dx));
                mul_b = 26'(r_idx);
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_active = r_active;
        n_axis   = r_axis;
        n_px     = r_px;
        n_res    = r_res;
        ucmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.func == FUNC_MOVE) begin
                        n_active = 1'b0;
                        n_state  = S_SQX;
                    end else if (r_active && r_cnt != 17'd0) begin
                        n_idx = idx_inc;
                        if (idx_inc >= r_cnt) begin
                            n_active = 1'b0;
                            n_res    = '{kind: KIND_POINT, pos_x: end_x, pos_y: end_y,
                                         step_dwell: '0, laser_enable: 1'b0, last: 1'b1};
                            n_state  = S_OUT;
                        end else begin
                            n_axis  = 1'b0;
                            n_state = S_PX;
                        end
                    end
                end
            end
            S_SQX: n_state = S_SQY;
            S_SQY: n_state = S_SQS;
            S_SQS: begin
                ucmd.start = 1'b1;
                ucmd.mode  = UM_SQRT;
                ucmd.src   = {(34'(r_sq) + 34'(r_p[32:0])), 16'b0};
                ucmd.steps = 5'd25;
                n_state    = S_ROOT;
            end
            S_ROOT: if (ustat.done) n_state = S_CLS;
            S_CLS: begin
                if (r_dist < 25'd128) begin
                    n_res   = '{kind: KIND_NONE, pos_x: end_x, pos_y: end_y,
                                step_dwell: '0, laser_enable: r_laser, last: 1'b0};
                    n_state = S_OUT;
                end else if (r_feed == 16'd0) begin
                    n_res   = '{kind: KIND_JUMP, pos_x: end_x, pos_y: end_y,
                                step_dwell: '0, laser_enable: r_laser, last: 1'b1};
                    n_state = S_OUT;
                end else begin
                    n_cnt   = steps;
                    n_idx   = '0;
                    n_state = S_M2;
                end
            end
            S_M2: n_state = S_M3;
            S_M3: n_state = S_M4;
            S_M4: n_state = S_CHK;
            S_CHK: begin
                if (57'(r_num[50:20]) >= r_den) begin
                    n_active = 1'b1;
                    n_res    = '{kind: KIND_START, pos_x: r_ox, pos_y: r_oy,
                                 step_dwell: DWELL_MAX, laser_enable: r_laser, last: 1'b0};
                    n_state  = S_OUT;
                end else begin
                    ucmd.start = 1'b1;
                    ucmd.mode  = UM_DIV;
                    ucmd.rem   = 58'(r_num[50:20]);
                    ucmd.src   = {r_num[19:0], 30'b0};
                    ucmd.div   = r_den;
                    ucmd.steps = 5'd20;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                if (ustat.done) begin
                    n_active = 1'b1;
                    n_res    = '{kind: KIND_START, pos_x: r_ox, pos_y: r_oy,
                                 step_dwell: (ustat.acc[19:0] == 20'd0) ? 20'd1
                                                                         : ustat.acc[19:0],
                                 laser_enable: r_laser, last: 1'b0};
                    n_state  = S_OUT;
                end
            end
            S_PX: n_state = S_PM;
            S_PM: n_state = S_PSUM;
            S_PSUM: begin
                ucmd.start = 1'b1;
                ucmd.mode  = UM_DIV;
                ucmd.rem   = 58'(tnum_c[39:17]);
                ucmd.src   = {tnum_c[16:0], 33'b0};
                ucmd.div   = 57'({r_cnt, 1'b0});
                ucmd.steps = 5'd17;
                n_state    = S_PDIV;
            end
            S_PDIV: begin
                if (ustat.done) begin
                    if (!r_axis) begin
                        n_px    = ustat.acc[15:0];
                        n_axis  = 1'b1;
                        n_state = S_PX;
                    end else begin
                        n_res   = '{kind: KIND_POINT, pos_x: r_px, pos_y: ustat.acc[15:0],
                                    step_dwell: '0, laser_enable: 1'b0, last: 1'b0};
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_feed   <= '0;
            r_stop   <= 1'b0;
            r_guide  <= 1'b0;
            r_ox     <= '0;
            r_oy     <= '0;
            r_dx     <= '0;
            r_dy     <= '0;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_active <= 1'b0;
            r_axis   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_active <= n_active;
            r_axis   <= n_axis;
            // config writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FEED:  r_feed  <= i_cfg_data;
                    CFG_STOP:  r_stop  <= i_cfg_data[0];
                    CFG_GUIDE: r_guide <= i_cfg_data[0];
                    default:   ;
                endcase
            end
            // move beat latches start and delta
            if (r_state == S_IDLE && i_in_valid && i_in_data.func == FUNC_MOVE) begin
                r_ox <= i_in_data.start_x;
                r_oy <= i_in_data.start_y;
                r_dx <= 17'({1'b0, i_in_data.target_x}) - 17'({1'b0, i_in_data.start_x});
                r_dy <= 17'({1'b0, i_in_data.target_y}) - 17'({1'b0, i_in_data.start_y});
            end
            // output register
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_p   <= 60'(mul_a * $signed({1'b0, mul_b}));
        r_px  <= n_px;
        r_res <= n_res;
        if (r_state == S_IDLE) r_laser <= !r_stop && !r_guide;
        if (r_state == S_SQY)  r_sq    <= r_p[32:0];
        if (r_state == S_ROOT && ustat.done) r_dist <= ustat.acc;
        if (r_state == S_M2)   r_num   <= r_p[50:0];
        if (r_state == S_M4)   r_den   <= {r_p[48:0], 8'b0};
        if (r_state == S_PM)   r_t     <= r_p[34:0];
        if (r_state == S_OUT && out_free) r_odata <= r_res;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule

>>> hdl/glmi_chk.sv
// port checker for the galvo linear move interpolator, bound to the top level
// depends on glmi_pkg
module glmi_chk import glmi_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // a stalled output beat stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output beat dropped or changed under stall");

    // a move beat keeps the block busy for the following cycle
    a_move_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.func == FUNC_MOVE |=> o_in_stall)
        else $error("move beat did not start the sequencer");

    // a timed move start never carries a zero dwell
    a_dwell_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_START |-> o_out_data.step_dwell != 20'd0)
        else $error("timed move with zero dwell");

    // path points never request the laser and carry no dwell
    a_point_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_POINT
            |-> !o_out_data.laser_enable && o_out_data.step_dwell == 20'd0)
        else $error("path point with laser request or dwell");

endmodule

bind galvo_linear_move_interpolator glmi_chk u_glmi_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);
